@@ design/rru_pkg.sv @@
// Shared types, constants and fixed-point helpers for the ray reflect/refract unit.
package rru_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE_Q     = 1 << FRAC_BITS;
  localparam int MIX_W     = (ONE_Q + 5) / 10;

  // Square root sizing: radicand is a nonnegative 31-bit value shifted up by FRAC_BITS
  localparam int SQ_VW  = 31 + FRAC_BITS;
  localparam int SQ_RW  = (SQ_VW + 1) / 2;
  localparam int SQ_TW  = 2 * SQ_RW + 2;
  localparam int SQ_BPS = 2;
  localparam int SQ_NST = (SQ_RW + SQ_BPS - 1) / SQ_BPS;

  // Fresnel format conversion to 16 fraction bits
  localparam int FR_SHR = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int FR_SHL = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  // Register indexes
  localparam logic [1:0] REG_BIAS         = 2'd0;
  localparam logic [1:0] REG_ETA_ENTERING = 2'd1;
  localparam logic [1:0] REG_ETA_LEAVING  = 2'd2;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    logic mode;
    logic inside_req;
    q_t   dir_x;
    q_t   dir_y;
    q_t   dir_z;
    q_t   hit_x;
    q_t   hit_y;
    q_t   hit_z;
    q_t   norm_x;
    q_t   norm_y;
    q_t   norm_z;
  } item_t;

  typedef struct packed {
    q_t          origin_x;
    q_t          origin_y;
    q_t          origin_z;
    q_t          out_dir_x;
    q_t          out_dir_y;
    q_t          out_dir_z;
    logic        total_reflection;
    logic [16:0] fresnel;
  } result_t;

  typedef struct packed {
    logic [16:0] bias;
    logic [17:0] eta_entering;
    logic [17:0] eta_leaving;
  } cfg_t;

  // Per-item data carried alongside the square root
  typedef struct packed {
    logic          mode;
    logic          tir;
    q_t [2:0]      org;
    q_t [2:0]      rdir;
    q_t [2:0]      de;
    q_t [2:0]      n;
    q_t            ec;
    q_t            frm;
  } side_t;

  function automatic q_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return q_t'(32'h7fff_ffff);
    end else if (v < -64'sd2147483648) begin
      return q_t'(32'h8000_0000);
    end
    return q_t'(v[31:0]);
  endfunction

  // Floor of a*b / 2^FRAC_BITS, saturated
  function automatic q_t mulq(input q_t a, input q_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return sat32(p >>> FRAC_BITS);
  endfunction

endpackage

@@ design/rru_front.sv @@
// Front pipeline: dot product, products, Fresnel cube and the refraction radicand.
module rru_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           item_valid,
  input  rru_pkg::item_t item,
  input  rru_pkg::cfg_t  cfg,
  output logic           f_valid,
  output logic [rru_pkg::SQ_VW-1:0] rad,
  output rru_pkg::side_t side
);

  // Stage 1: per-axis d*n
  logic           v1;
  rru_pkg::item_t it1;
  rru_pkg::q_t    eta1;
  rru_pkg::q_t [2:0] p1;

  // Stage 2: dot and cosine
  logic           v2;
  rru_pkg::item_t it2;
  rru_pkg::q_t    eta2, dot2, cosi2;

  // Stage 3: products
  logic           v3;
  rru_pkg::item_t it3;
  rru_pkg::q_t    c2_3, ec3, e2_3, base3;
  rru_pkg::q_t [2:0] nb3, nd3, de3;

  // Stage 4
  logic           v4, mode4;
  rru_pkg::q_t    ec4, e2_4, t1_4, b2_4, base4;
  rru_pkg::q_t [2:0] org4, rdir4, de4, n4;

  // Stage 5
  logic           v5, mode5;
  rru_pkg::q_t    ec5, m5, cube5;
  rru_pkg::q_t [2:0] org5, rdir5, de5, n5;

  rru_pkg::q_t [2:0] d_in, n_in, d2, n2, d3, h3, n3;
  logic signed [63:0] k5;
  rru_pkg::q_t    ks5;

  assign d_in = {item.dir_z, item.dir_y, item.dir_x};
  assign n_in = {item.norm_z, item.norm_y, item.norm_x};
  assign d2   = {it2.dir_z, it2.dir_y, it2.dir_x};
  assign n2   = {it2.norm_z, it2.norm_y, it2.norm_x};
  assign d3   = {it3.dir_z, it3.dir_y, it3.dir_x};
  assign h3   = {it3.hit_z, it3.hit_y, it3.hit_x};
  assign n3   = {it3.norm_z, it3.norm_y, it3.norm_x};
  assign k5   = 64'(rru_pkg::ONE_Q) - 64'(m5);
  assign ks5  = rru_pkg::sat32(k5);

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      f_valid <= 1'b0;
    end else if (en) begin
      v1 <= item_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      f_valid <= v5;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      it1  <= item;
      eta1 <= item.inside_req ? rru_pkg::q_t'({14'd0, cfg.eta_leaving})
                              : rru_pkg::q_t'({14'd0, cfg.eta_entering});
      for (int i = 0; i < 3; i++) begin
        p1[i] <= rru_pkg::mulq(d_in[i], n_in[i]);
      end

      it2   <= it1;
      eta2  <= eta1;
      dot2  <= rru_pkg::sat32(64'(p1[0]) + 64'(p1[1]) + 64'(p1[2]));
      cosi2 <= rru_pkg::sat32(-64'(rru_pkg::sat32(64'(p1[0]) + 64'(p1[1]) + 64'(p1[2]))));

      it3   <= it2;
      c2_3  <= rru_pkg::mulq(cosi2, cosi2);
      ec3   <= rru_pkg::mulq(eta2, cosi2);
      e2_3  <= rru_pkg::mulq(eta2, eta2);
      base3 <= rru_pkg::sat32(64'(rru_pkg::ONE_Q) - 64'(cosi2));
      for (int i = 0; i < 3; i++) begin
        nb3[i] <= rru_pkg::mulq(n2[i], rru_pkg::q_t'({15'd0, cfg.bias}));
        nd3[i] <= rru_pkg::mulq(n2[i], dot2);
        de3[i] <= rru_pkg::mulq(d2[i], eta2);
      end

      mode4 <= it3.mode;
      ec4   <= ec3;
      e2_4  <= e2_3;
      t1_4  <= rru_pkg::sat32(64'(rru_pkg::ONE_Q) - 64'(c2_3));
      b2_4  <= rru_pkg::mulq(base3, base3);
      base4 <= base3;
      for (int i = 0; i < 3; i++) begin
        org4[i]  <= it3.mode ? rru_pkg::sat32(64'(h3[i]) - 64'(nb3[i]))
                             : rru_pkg::sat32(64'(h3[i]) + 64'(nb3[i]));
        rdir4[i] <= rru_pkg::sat32(64'(d3[i]) - 2 * 64'(nd3[i]));
      end
      de4 <= de3;
      n4  <= n3;

      mode5 <= mode4;
      ec5   <= ec4;
      m5    <= rru_pkg::mulq(e2_4, t1_4);
      cube5 <= rru_pkg::mulq(b2_4, base4);
      org5  <= org4;
      rdir5 <= rdir4;
      de5   <= de4;
      n5    <= n4;

      // Flag total internal reflection and form the radicand
      side.mode <= mode5;
      side.tir  <= mode5 && k5 < 0;
      side.org  <= org5;
      side.rdir <= rdir5;
      side.de   <= de5;
      side.n    <= n5;
      side.ec   <= ec5;
      side.frm  <= rru_pkg::mulq(cube5, rru_pkg::q_t'(rru_pkg::ONE_Q - rru_pkg::MIX_W));
      rad       <= (k5 < 0) ? '0 : {ks5[30:0], rru_pkg::FRAC_BITS'(0)};
    end
  end

endmodule

@@ design/rru_sqrt.sv @@
// Pipelined restoring square root, two root bits per stage, with sideband data.
module rru_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_v,
  input  logic [rru_pkg::SQ_VW-1:0] rad,
  input  rru_pkg::side_t in_side,
  output logic           out_v,
  output logic [rru_pkg::SQ_RW-1:0] root,
  output rru_pkg::side_t out_side
);

  localparam int NST = rru_pkg::SQ_NST;
  localparam int TW  = rru_pkg::SQ_TW;
  localparam int RW  = rru_pkg::SQ_RW;

  logic [NST-1:0]   sv;
  logic [TW-1:0]    srem  [NST];
  logic [RW-1:0]    sroot [NST];
  rru_pkg::side_t   sside [NST];

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [TW-1:0] rem_next;
    logic [RW-1:0] root_next;

    // Decide this stage's root bits, most significant first
    always_comb begin : step
      logic [TW-1:0] trial;
      int ib;
      if (s == 0) begin
        rem_next  = TW'(rad);
        root_next = '0;
      end else begin
        rem_next  = srem[(s == 0) ? 0 : s - 1];
        root_next = sroot[(s == 0) ? 0 : s - 1];
      end
      for (int j = 0; j < rru_pkg::SQ_BPS; j++) begin
        ib = RW - 1 - s * rru_pkg::SQ_BPS - j;
        trial = '0;
        if (ib >= 0) begin
          trial = (TW'(root_next) << (ib + 1)) + (TW'(1) << (2 * ib));
          if (rem_next >= trial) begin
            rem_next  = rem_next - trial;
            root_next = root_next | (RW'(1) << ib);
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[s] <= 1'b0;
      end else if (en) begin
        sv[s] <= (s == 0) ? in_v : sv[(s == 0) ? 0 : s - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        srem[s]  <= rem_next;
        sroot[s] <= root_next;
        sside[s] <= (s == 0) ? in_side : sside[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign out_v    = sv[NST-1];
  assign root     = sroot[NST-1];
  assign out_side = sside[NST-1];

endmodule

@@ design/rru_back.sv @@
// Back pipeline: refraction direction, Fresnel clamp and the output register.
module rru_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_v,
  input  logic [rru_pkg::SQ_RW-1:0] root,
  input  rru_pkg::side_t in_side,
  output logic           result_valid,
  output rru_pkg::result_t result
);

  logic              v1, v2;
  rru_pkg::side_t    sd1, sd2;
  rru_pkg::q_t       a1;
  rru_pkg::q_t [2:0] mna2;
  rru_pkg::q_t [2:0] dir_next;
  logic signed [63:0] fr_sum;
  logic [rru_pkg::FRAC_BITS:0] fr_clamp;
  logic [16:0]       fr16;

  // Pick direction: zero on total reflection, mirror ray or refracted ray
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (sd2.tir) begin
        dir_next[i] = '0;
      end else if (sd2.mode) begin
        dir_next[i] = rru_pkg::sat32(64'(sd2.de[i]) + 64'(mna2[i]));
      end else begin
        dir_next[i] = sd2.rdir[i];
      end
    end
  end

  // Clamp Fresnel weight to 0..1 and move it to 16 fraction bits
  always_comb begin
    fr_sum = 64'(rru_pkg::MIX_W) + 64'(sd2.frm);
    if (fr_sum < 0) begin
      fr_clamp = '0;
    end else if (fr_sum > 64'(rru_pkg::ONE_Q)) begin
      fr_clamp = (rru_pkg::FRAC_BITS + 1)'(rru_pkg::ONE_Q);
    end else begin
      fr_clamp = fr_sum[rru_pkg::FRAC_BITS:0];
    end
    fr16 = 17'((32'(fr_clamp) >> rru_pkg::FR_SHR) << rru_pkg::FR_SHL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_v;
      v2 <= v1;
      result_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd1 <= in_side;
      a1  <= rru_pkg::sat32(64'(in_side.ec) - 64'($signed({1'b0, root})));
      sd2 <= sd1;
      for (int i = 0; i < 3; i++) begin
        mna2[i] <= rru_pkg::mulq(sd1.n[i], a1);
      end
      result.origin_x  <= sd2.tir ? '0 : sd2.org[0];
      result.origin_y  <= sd2.tir ? '0 : sd2.org[1];
      result.origin_z  <= sd2.tir ? '0 : sd2.org[2];
      result.out_dir_x <= dir_next[0];
      result.out_dir_y <= dir_next[1];
      result.out_dir_z <= dir_next[2];
      result.total_reflection <= sd2.tir;
      result.fresnel   <= fr16;
    end
  end

endmodule

@@ design/ray_reflect_refract_unit_core.sv @@
// Top level of the ray reflect/refract unit: config registers, pipeline and flow control.
// Takes one ray per cycle while item_stall is low and returns one new ray (origin,
// direction, total internal reflection flag, Fresnel weight) per ray, in order.
// The square root, which resolves two root bits per stage, sets most of the
// pipeline depth. The whole pipeline holds while a result waits under result_stall,
// so item_stall follows result_valid and result_stall. Configuration is to be
// written through cfg_we/cfg_index/cfg_data only while no items are in flight;
// the block does not enforce this. An unused index is ignored.
module ray_reflect_refract_unit_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  rru_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output rru_pkg::result_t  result,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [17:0]       cfg_data
);

  rru_pkg::cfg_t  cfg;
  logic           en;
  logic           f_valid, s_valid;
  logic [rru_pkg::SQ_VW-1:0] rad;
  logic [rru_pkg::SQ_RW-1:0] root;
  rru_pkg::side_t f_side, s_side;

  // Hold everything while the output waits
  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bias         <= 17'd66;
      cfg.eta_entering <= 18'd59578;
      cfg.eta_leaving  <= 18'd72090;
    end else if (cfg_we) begin
      case (cfg_index)
        rru_pkg::REG_BIAS:         cfg.bias         <= cfg_data[16:0];
        rru_pkg::REG_ETA_ENTERING: cfg.eta_entering <= cfg_data;
        rru_pkg::REG_ETA_LEAVING:  cfg.eta_leaving  <= cfg_data;
        default: ;
      endcase
    end
  end

  rru_front u_front (
    .clk, .rst, .en,
    .item_valid, .item, .cfg,
    .f_valid, .rad, .side(f_side)
  );

  rru_sqrt u_sqrt (
    .clk, .rst, .en,
    .in_v(f_valid), .rad, .in_side(f_side),
    .out_v(s_valid), .root, .out_side(s_side)
  );

  rru_back u_back (
    .clk, .rst, .en,
    .in_v(s_valid), .root, .in_side(s_side),
    .result_valid, .result
  );

endmodule

@@ design/rru_checker.sv @@
// Port-level checks for the ray reflect/refract unit, bound to the top level.
module rru_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_stall,
  input logic             result_valid,
  input logic             result_stall,
  input rru_pkg::result_t result
);

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // Input stalls exactly when a result is held back
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    item_stall == (result_valid && result_stall))
    else $error("item stall does not follow output backpressure");

  // Total reflection clears the ray
  a_tir_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.total_reflection) |->
      (result.origin_x == 0 && result.origin_y == 0 && result.origin_z == 0 &&
       result.out_dir_x == 0 && result.out_dir_y == 0 && result.out_dir_z == 0))
    else $error("ray not zero on total reflection");

  // Fresnel weight stays within 0..1
  a_fresnel_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.fresnel <= 17'd65536)
    else $error("fresnel out of range");

  // Held result does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule

bind ray_reflect_refract_unit_core rru_checker u_rru_checker (.*);

@@ tb/sv/tb_ray_reflect_refract_unit_core.sv @@
// Self-checking testbench for the ray reflect/refract unit core.
`timescale 1ns / 1ps

module tb_ray_reflect_refract_unit_core;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_PER_PHASE = 306;

  typedef struct {
    rru_pkg::item_t   ray;
    bit               typed;
    rru_pkg::result_t want;
  } ray_job_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  rru_pkg::item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  rru_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = rru_pkg::REG_BIAS;
  logic [17:0] cfg_data = '0;

  // Register mirror, reset values
  longint bias_m = 66;
  longint eta_in_m = 59578;
  longint eta_out_m = 72090;

  ray_job_t ray_feed[$];
  rru_pkg::result_t  ray_expect[$];
  int queued_n = 0;
  int sent_n = 0;
  int err_n = 0;
  int burst_left = 0;
  int gap_left = 0;
  int idle_cyc = 0;
  int stall_mode = 0;
  int stall_cyc = 0;

  ray_reflect_refract_unit_core dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fxmul(longint a, longint b);
    longint p;
    p = a * b;
    return clamp32(p >>> rru_pkg::FRAC_BITS);
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned acc;
    longint unsigned bitv;
    acc = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= acc + bitv) begin
        v = v - (acc + bitv);
        acc = (acc >> 1) + bitv;
      end else begin
        acc = acc >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(acc);
  endfunction

  // Expected new ray for one incoming ray under the current registers
  function automatic rru_pkg::result_t predict_ray(rru_pkg::item_t r);
    rru_pkg::result_t o;
    longint d[3], h[3], n[3], org[3], dv[3];
    longint one, mixw, dotv, cosi, eta, c2, t1, e2, k, sq, a, base, cube, fr;
    one = longint'(1) << rru_pkg::FRAC_BITS;
    mixw = (one + 5) / 10;
    d[0] = r.dir_x;  d[1] = r.dir_y;  d[2] = r.dir_z;
    h[0] = r.hit_x;  h[1] = r.hit_y;  h[2] = r.hit_z;
    n[0] = r.norm_x; n[1] = r.norm_y; n[2] = r.norm_z;
    dotv = clamp32(fxmul(d[0], n[0]) + fxmul(d[1], n[1]) + fxmul(d[2], n[2]));
    cosi = clamp32(-dotv);
    o.total_reflection = 1'b0;
    if (!r.mode) begin
      for (int i = 0; i < 3; i++) begin
        org[i] = clamp32(h[i] + fxmul(n[i], bias_m));
        dv[i] = clamp32(d[i] - 2 * fxmul(n[i], dotv));
      end
    end else begin
      eta = r.inside_req ? eta_out_m : eta_in_m;
      c2 = fxmul(cosi, cosi);
      t1 = clamp32(one - c2);
      e2 = fxmul(eta, eta);
      k = one - fxmul(e2, t1);
      if (k < 0) begin
        o.total_reflection = 1'b1;
        for (int i = 0; i < 3; i++) begin
          org[i] = 0;
          dv[i] = 0;
        end
      end else begin
        k = clamp32(k);
        sq = root_floor(longint'(k) << rru_pkg::FRAC_BITS);
        a = clamp32(fxmul(eta, cosi) - sq);
        for (int i = 0; i < 3; i++) begin
          org[i] = clamp32(h[i] - fxmul(n[i], bias_m));
          dv[i] = clamp32(fxmul(d[i], eta) + fxmul(n[i], a));
        end
      end
    end
    base = clamp32(one - cosi);
    cube = fxmul(fxmul(base, base), base);
    fr = mixw + fxmul(cube, one - mixw);
    if (fr < 0) fr = 0;
    if (fr > one) fr = one;
    if (rru_pkg::FRAC_BITS >= 16) fr = fr >>> (rru_pkg::FRAC_BITS - 16);
    else fr = fr <<< (16 - rru_pkg::FRAC_BITS);
    o.origin_x = org[0][31:0]; o.origin_y = org[1][31:0]; o.origin_z = org[2][31:0];
    o.out_dir_x = dv[0][31:0]; o.out_dir_y = dv[1][31:0]; o.out_dir_z = dv[2][31:0];
    o.fresnel = fr[16:0];
    return o;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    if (got != want) begin
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      err_n++;
    end
  endtask

  // Sender: bursts of random length, random gaps between them
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) begin
        sent_n <= sent_n + 1;
      end
      if (!item_valid || !item_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          item_valid <= 1'b0;
        end else if (ray_feed.size() > 0) begin
          ray_job_t job;
          job = ray_feed.pop_front();
          item <= job.ray;
          item_valid <= 1'b1;
          ray_expect.push_back(job.typed ? job.want : predict_ray(job.ray));
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern switches among none, random and long blocks
  always @(posedge clk) begin
    if (!rst) begin
      stall_cyc <= stall_cyc + 1;
      if (stall_cyc % 64 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        1: begin
          result_stall <= 1'($urandom_range(0, 1));
        end
        2: begin
          result_stall <= (stall_cyc % 16) < 10;
        end
        default: begin
          result_stall <= 1'b0;
        end
      endcase
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (ray_expect.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        err_n++;
      end else begin
        rru_pkg::result_t w;
        w = ray_expect.pop_front();
        report_mismatch("origin_x", result.origin_x, w.origin_x);
        report_mismatch("origin_y", result.origin_y, w.origin_y);
        report_mismatch("origin_z", result.origin_z, w.origin_z);
        report_mismatch("out_dir_x", result.out_dir_x, w.out_dir_x);
        report_mismatch("out_dir_y", result.out_dir_y, w.out_dir_y);
        report_mismatch("out_dir_z", result.out_dir_z, w.out_dir_z);
        report_mismatch("total_reflection", result.total_reflection, w.total_reflection);
        report_mismatch("fresnel", result.fresnel, w.fresnel);
      end
    end
  end

  // Watchdog: count cycles without progress while work is outstanding
  always @(posedge clk) begin
    if (!rst) begin
      if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
          (ray_feed.size() == 0 && ray_expect.size() == 0 && !item_valid)) begin
        idle_cyc <= 0;
      end else if (idle_cyc >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cyc <= idle_cyc + 1;
      end
    end
  end

  task automatic queue_ray(rru_pkg::item_t r, bit typed, rru_pkg::result_t want);
    ray_job_t job;
    job.ray = r;
    job.typed = typed;
    job.want = want;
    ray_feed.push_back(job);
    queued_n++;
  endtask

  // Hold until every queued item is accepted and every result has come
  task automatic drain;
    while (sent_n != queued_n || ray_expect.size() != 0 || item_valid) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [17:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rru_pkg::REG_BIAS: begin
        bias_m = val & 18'h1FFFF;
      end
      rru_pkg::REG_ETA_ENTERING: begin
        eta_in_m = val;
      end
      rru_pkg::REG_ETA_LEAVING: begin
        eta_out_m = val;
      end
      default: begin
      end
    endcase
  endtask

  function automatic rru_pkg::q_t near_unit();
    return rru_pkg::q_t'($signed($urandom_range(0, 2 * 70000)) - 70000);
  endfunction

  function automatic rru_pkg::q_t any_q();
    return rru_pkg::q_t'($urandom);
  endfunction

  // Mostly well-formed rays, some raw noise in any field
  function automatic rru_pkg::item_t make_ray();
    rru_pkg::item_t r;
    int kind;
    kind = $urandom_range(0, 9);
    r.mode = 1'($urandom_range(0, 1));
    r.inside_req = 1'($urandom_range(0, 1));
    if (kind < 7) begin
      r.dir_x = near_unit(); r.dir_y = near_unit(); r.dir_z = near_unit();
      r.norm_x = near_unit(); r.norm_y = near_unit(); r.norm_z = near_unit();
      if ($urandom_range(0, 3) == 0) begin
        r.hit_x = any_q(); r.hit_y = any_q(); r.hit_z = any_q();
      end else begin
        r.hit_x = rru_pkg::q_t'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        r.hit_y = rru_pkg::q_t'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        r.hit_z = rru_pkg::q_t'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      end
    end else if (kind < 9) begin
      r.dir_x = any_q(); r.dir_y = any_q(); r.dir_z = any_q();
      r.hit_x = any_q(); r.hit_y = any_q(); r.hit_z = any_q();
      r.norm_x = any_q(); r.norm_y = any_q(); r.norm_z = any_q();
    end else begin
      r.dir_x = near_unit(); r.dir_y = any_q(); r.dir_z = near_unit();
      r.hit_x = any_q(); r.hit_y = near_unit(); r.hit_z = any_q();
      r.norm_x = any_q(); r.norm_y = near_unit(); r.norm_z = near_unit();
    end
    return r;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) queue_ray(make_ray(), 1'b0, '0);
  endtask

  localparam rru_pkg::q_t QMAX = 32'sh7fff_ffff;
  localparam rru_pkg::q_t QMIN = 32'sh8000_0000;
  localparam rru_pkg::q_t QONE = 32'sh0001_0000;
  localparam rru_pkg::q_t QNEG = -32'sh0001_0000;

  initial begin
    ray_job_t rows[$];
    rru_pkg::item_t r;
    rru_pkg::result_t w;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table: typed results only where they read off at a glance
    w = '0;
    w.fresnel = 17'd65536;
    rows.push_back('{'0, 1'b1, w});
    r = '0; r.mode = 1'b1;
    rows.push_back('{r, 1'b1, w});
    // Leaving with eta above one and grazing angle: total internal reflection
    r = '0; r.mode = 1'b1; r.inside_req = 1'b1;
    w.total_reflection = 1'b1;
    rows.push_back('{r, 1'b1, w});
    // Head-on hit on a unit normal, both modes and both eta choices
    for (int m = 0; m < 4; m++) begin
      r = '0; r.mode = m[0]; r.inside_req = m[1];
      r.dir_y = QNEG; r.norm_y = QONE; r.hit_x = 32'sd12345;
      rows.push_back('{r, 1'b0, '0});
    end
    // Unoriented normal: weight saturates to one
    r = '0; r.dir_y = QNEG; r.norm_y = QNEG;
    rows.push_back('{r, 1'b0, '0});
    // Normal too long: weight goes below zero and clamps
    r = '0; r.mode = 1'b1; r.dir_y = QNEG; r.norm_y = 32'sd131072;
    rows.push_back('{r, 1'b0, '0});
    // Field extremes, to saturate products and sums
    for (int m = 0; m < 4; m++) begin
      r.mode = m[0]; r.inside_req = m[1];
      r.dir_x = QMAX; r.dir_y = QMIN; r.dir_z = QMAX;
      r.hit_x = QMAX; r.hit_y = QMIN; r.hit_z = QMAX;
      r.norm_x = m[1] ? QMIN : QMAX; r.norm_y = QMAX; r.norm_z = QMIN;
      rows.push_back('{r, 1'b0, '0});
      r.dir_x = QMIN; r.dir_y = QMIN; r.dir_z = QMIN;
      r.hit_x = QMIN; r.hit_y = QMIN; r.hit_z = QMIN;
      r.norm_x = QMIN; r.norm_y = QMIN; r.norm_z = QMIN;
      rows.push_back('{r, 1'b0, '0});
      r.dir_x = '1; r.dir_y = QONE; r.dir_z = '1;
      r.hit_x = QMAX; r.hit_y = QMAX; r.hit_z = QMIN;
      r.norm_x = QONE; r.norm_y = '1; r.norm_z = QNEG;
      rows.push_back('{r, 1'b0, '0});
    end
    foreach (rows[i]) queue_ray(rows[i].ray, rows[i].typed, rows[i].want);
    random_phase(RAND_PER_PHASE - rows.size());
    drain();

    // Unit bias, steepest and zero eta
    write_reg(rru_pkg::REG_BIAS, 18'd65536);
    write_reg(rru_pkg::REG_ETA_ENTERING, 18'd262143);
    write_reg(rru_pkg::REG_ETA_LEAVING, 18'd0);
    random_phase(RAND_PER_PHASE);
    drain();

    // Zero bias, swapped extremes; an unused index is ignored
    write_reg(rru_pkg::REG_BIAS, 18'd0);
    write_reg(rru_pkg::REG_ETA_ENTERING, 18'd0);
    write_reg(rru_pkg::REG_ETA_LEAVING, 18'd262143);
    write_reg(REG_UNUSED, 18'h2AAAA);
    random_phase(RAND_PER_PHASE);
    drain();

    write_reg(rru_pkg::REG_BIAS, 18'($urandom_range(0, 65536)));
    write_reg(rru_pkg::REG_ETA_ENTERING, 18'($urandom_range(0, 262143)));
    write_reg(rru_pkg::REG_ETA_LEAVING, 18'($urandom_range(0, 262143)));
    random_phase(RAND_PER_PHASE);
    drain();

    // Glass-like ratios with a small offset
    write_reg(rru_pkg::REG_BIAS, 18'd1);
    write_reg(rru_pkg::REG_ETA_ENTERING, 18'd43691);
    write_reg(rru_pkg::REG_ETA_LEAVING, 18'd98304);
    random_phase(RAND_PER_PHASE);
    drain();

    if (err_n == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
